// ----- src/rct_pkg.sv -----
// shared types and constants for the recent connection table
package rct_pkg;

    // request command codes
    localparam logic CMD_OFFER = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // entry limit after reset
    localparam logic [7:0] LIMIT_RESET = 8'd100;

    // cells per first-level reduction group
    localparam int GROUP_SIZE = 16;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] source_port;
        logic [15:0] dst_port;
    } conn_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] source_port;
        logic [15:0] dst_port;
        logic [6:0]  read_index;
    } rct_request_t;

    typedef struct packed {
        logic        inserted_new;
        logic        evicted_oldest;
        logic        entry_valid;
        logic [31:0] entry_src_addr;
        logic [31:0] entry_dst_addr;
        logic [15:0] entry_source_port;
        logic [15:0] entry_dst_port;
        logic [7:0]  occupancy;
    } rct_result_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic       shift;
        conn_t      tuple;
        logic [6:0] read_index;
    } rct_bcast_t;

    // what one cell reports: tuple match, read hit and its tuple on a hit
    typedef struct packed {
        logic  match;
        logic  hit;
        conn_t tuple;
    } rct_probe_t;

endpackage

// ----- src/rct_cell.sv -----
// one table cell: a stored tuple, its valid bit and its compare logic
module rct_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rct_pkg::rct_bcast_t bcast,
    input  logic [CNT_W-1:0]    keep,
    input  rct_pkg::conn_t      prev_tuple,
    output rct_pkg::conn_t      tuple_out,
    output rct_pkg::rct_probe_t probe
);
    import rct_pkg::*;

    localparam int IW = (CNT_W > 7) ? CNT_W : 7;

    conn_t         tuple_reg;
    logic          valid_reg;
    logic          retain;
    logic [IW-1:0] idx_ext;
    logic          hit;

    // this age position survives the insert
    assign retain  = CNT_W'(INDEX) < keep;
    assign idx_ext = IW'(bcast.read_index);
    assign hit     = valid_reg && (idx_ext == IW'(INDEX));

    // state update: take the neighbour's tuple on an insert
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (bcast.shift) begin
            valid_reg <= retain;
        end
    end

    always_ff @(posedge aclk) begin
        if (bcast.shift && retain) begin
            tuple_reg <= prev_tuple;
        end
    end

    // match and read probes
    always_comb begin
        probe.match = valid_reg && (tuple_reg == bcast.tuple);
        probe.hit   = hit;
        probe.tuple = hit ? tuple_reg : '0;
    end

    assign tuple_out = tuple_reg;

endmodule

// ----- src/rct_probe_tree.sv -----
// two-stage registered or-tree over the cell probes
module rct_probe_tree #(
    parameter int N = 128
) (
    input  logic                aclk,
    input  rct_pkg::rct_probe_t probes [N],
    output rct_pkg::rct_probe_t merged
);
    import rct_pkg::*;

    localparam int NG = (N + GROUP_SIZE - 1) / GROUP_SIZE;

    rct_probe_t pad [NG*GROUP_SIZE];
    rct_probe_t grp_next [NG];
    rct_probe_t grp_reg [NG];
    rct_probe_t merged_next;
    rct_probe_t merged_reg;

    // pad the row out to whole groups
    for (genvar j = 0; j < NG*GROUP_SIZE; j++) begin : g_pad
        if (j < N) begin : g_real
            assign pad[j] = probes[j];
        end else begin : g_fill
            assign pad[j] = '0;
        end
    end

    // first level: or within each group
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                grp_next[g] = grp_next[g] | pad[g*GROUP_SIZE + k];
            end
        end
    end

    // second level: or across groups
    always_comb begin
        merged_next = '0;
        for (int g = 0; g < NG; g++) begin
            merged_next = merged_next | grp_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        grp_reg    <= grp_next;
        merged_reg <= merged_next;
    end

    assign merged = merged_reg;

endmodule

// ----- src/recent_connection_table.sv -----
// recent connection table: top level with controller and row of cells
// one request at a time, handled in steps: capture, two probe tree stages, finish
// a request is taken while the previous result still waits in the output register
// reset: synchronous active-low aresetn clears all valid bits and the count at once
// entry_limit returns to 100 on reset; no clearing pass is needed
module recent_connection_table #(
    parameter int CAPACITY = 128
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  rct_pkg::rct_request_t    s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output rct_pkg::rct_result_t     m_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [7:0]               cfg_data
);
    import rct_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW + 1 > 8) ? CW + 1 : 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GROUP,
        ST_MERGE,
        ST_DONE
    } state_t;

    state_t        state_reg;
    rct_request_t  req_reg;
    logic [7:0]    limit_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] keep_reg;
    logic          evict_reg;
    logic          m_valid_reg;
    rct_result_t   m_data_reg;
    rct_result_t   m_data_next;

    rct_bcast_t    bcast;
    rct_probe_t    probes [CAPACITY];
    conn_t         tuples [CAPACITY];
    conn_t         new_tuple;
    rct_probe_t    merged;
    logic          finish;
    logic          do_insert;
    logic [7:0]    lim8;
    logic [CMPW-1:0] lim_ext;
    logic [CMPW-1:0] grown;
    logic [CMPW-1:0] keep_next;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    // effective limit and the size after an insert
    always_comb begin
        lim8    = (limit_reg == 8'd0) ? 8'd1 : limit_reg;
        lim_ext = CMPW'(lim8);
        if (lim_ext > CMPW'(CAPACITY)) begin
            lim_ext = CMPW'(CAPACITY);
        end
        grown     = CMPW'(count_reg) + CMPW'(1);
        keep_next = (grown > lim_ext) ? lim_ext : grown;
    end

    assign new_tuple = '{src_addr: req_reg.src_addr, dst_addr: req_reg.dst_addr,
                         source_port: req_reg.source_port, dst_port: req_reg.dst_port};

    assign finish    = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign do_insert = finish && (req_reg.cmd == CMD_OFFER) && !merged.match;

    assign bcast.shift      = do_insert;
    assign bcast.tuple      = new_tuple;
    assign bcast.read_index = req_reg.read_index;

    // row of cells, each taking its younger neighbour's tuple on insert
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        conn_t prev;
        if (i == 0) begin : g_head
            assign prev = new_tuple;
        end else begin : g_link
            assign prev = tuples[i-1];
        end
        rct_cell #(
            .INDEX (i),
            .CNT_W (CW)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .bcast      (bcast),
            .keep       (keep_reg),
            .prev_tuple (prev),
            .tuple_out  (tuples[i]),
            .probe      (probes[i])
        );
    end

    rct_probe_tree #(
        .N (CAPACITY)
    ) u_tree (
        .aclk   (aclk),
        .probes (probes),
        .merged (merged)
    );

    // request capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
    end

    // sequencer, count and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            keep_reg    <= CW'(1);
            evict_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_GROUP;
                    end
                end
                ST_GROUP: begin
                    state_reg <= ST_MERGE;
                end
                ST_MERGE: begin
                    keep_reg  <= CW'(keep_next);
                    evict_reg <= grown > lim_ext;
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (finish) begin
                        state_reg <= ST_IDLE;
                        if (do_insert) begin
                            count_reg <= keep_reg;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result payload
    always_comb begin
        m_data_next                = '0;
        m_data_next.inserted_new   = do_insert;
        m_data_next.evicted_oldest = do_insert && evict_reg;
        m_data_next.occupancy      = do_insert ? 8'(keep_reg) : 8'(count_reg);
        if (req_reg.cmd == CMD_READ) begin
            m_data_next.entry_valid       = merged.hit;
            m_data_next.entry_src_addr    = merged.tuple.src_addr;
            m_data_next.entry_dst_addr    = merged.tuple.dst_addr;
            m_data_next.entry_source_port = merged.tuple.source_port;
            m_data_next.entry_dst_port    = merged.tuple.dst_port;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_data_reg <= m_data_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // occupancy never exceeds the row length
    assert property (@(posedge aclk) disable iff (!aresetn)
        CMPW'(count_reg) <= CMPW'(CAPACITY))
        else $error("count above capacity");

    // an accepted request enters the group stage next
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_GROUP))
        else $error("request not sequenced");

    // an eviction only comes with an insert
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.evicted_oldest) |-> m_data.inserted_new)
        else $error("eviction without insert");

    // insert and read hit never share a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.inserted_new) |-> !m_data.entry_valid)
        else $error("insert reported with read data");

    // a shift only happens while finishing an offer
    assert property (@(posedge aclk) disable iff (!aresetn)
        bcast.shift |-> (finish && (req_reg.cmd == CMD_OFFER)))
        else $error("stray shift");

endmodule
